@@ rtl/sidfr_pkg.sv @@
// sidfr_pkg: shared types and codes for the sync/id/length frame receiver
// used by sidfr_step and sync_id_length_frame_receiver; no dependencies
`default_nettype none

package sidfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned CFG_IDX_W = 8;

  // frame phases
  localparam logic [PHASE_W-1:0] PH_SYNC1    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SYNC2    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SENDER   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RECEIVER = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LEN_H    = 3'd4;
  localparam logic [PHASE_W-1:0] PH_LEN_L    = 3'd5;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD  = 3'd6;
  localparam logic [PHASE_W-1:0] PH_CHECK    = 3'd7;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_NONE          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PAYLOAD       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_GOOD          = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CHECK_ERR     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SYNC2_MISSING = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SENDER_BAD    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_RECEIVER_BAD  = 3'd6;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTNER_ID = 8'd1;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
  localparam logic [BYTE_W:0]   CHECK_MOD = 9'd255;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [BYTE_W-1:0]  running_sum;
    logic [LEN_W-1:0]   length;
    logic [LEN_W-1:0]   byte_counter;
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   payload_byte;
    logic [LEN_W-1:0]    payload_index;
    logic [LEN_W-1:0]    frame_length;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] own_id;
    logic [BYTE_W-1:0] partner_id;
  } ids_t;

endpackage

`default_nettype wire

@@ rtl/sync_id_length_frame_receiver.sv @@
// sync_id_length_frame_receiver: top level, config registers, parser state,
// output register with skid stage; depends on sidfr_pkg and sidfr_step
//
//   channel | ports                                   | direction
//   in      | in_valid in_ready in_rx_byte            | received word in
//   out     | out_valid out_ready out_status          | one result word per input word
//           | out_payload_byte out_payload_index      |
//           | out_frame_length                        |
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data  | id register writes
//
// one word per cycle while in_ready is high; each taken word's result is
// registered in the output register, or in the skid register while the
// output is held, after the single parser step; the skid stage holds one extra
// result, so in_ready drops only when both the output and skid registers are full; cfg_ready is always high
// rst_n clears the phase, sum, length, counter, ids and both valid flags
`default_nettype none

module sync_id_length_frame_receiver (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [sidfr_pkg::BYTE_W-1:0]        in_rx_byte,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [sidfr_pkg::STATUS_W-1:0]     out_status,
  output logic [sidfr_pkg::BYTE_W-1:0]       out_payload_byte,
  output logic [sidfr_pkg::LEN_W-1:0]        out_payload_index,
  output logic [sidfr_pkg::LEN_W-1:0]        out_frame_length,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [sidfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [sidfr_pkg::BYTE_W-1:0]        cfg_data
);

  sidfr_pkg::ids_t    ids_r;
  sidfr_pkg::state_t  st_r;
  sidfr_pkg::state_t  st_nxt;
  sidfr_pkg::result_t res;
  sidfr_pkg::result_t out_res_r;
  sidfr_pkg::result_t skid_res_r;
  logic               out_valid_r;
  logic               skid_valid_r;
  logic               in_acc;
  logic               out_free;

  sidfr_step u_step (
    .st      (st_r),
    .ids     (ids_r),
    .rx_byte (in_rx_byte),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  assign in_ready  = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ids_r.own_id       <= '0;
      ids_r.partner_id   <= '0;
      st_r.phase         <= sidfr_pkg::PH_SYNC1;
      st_r.running_sum   <= '0;
      st_r.length        <= '0;
      st_r.byte_counter  <= '0;
      out_valid_r        <= 1'b0;
      skid_valid_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          sidfr_pkg::CFG_OWN_ID:     ids_r.own_id     <= cfg_data;
          sidfr_pkg::CFG_PARTNER_ID: ids_r.partner_id <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // result words
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
      end else if (in_acc) begin
        out_res_r <= res;
      end
    end else if (in_acc) begin
      skid_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_payload_byte  = out_res_r.payload_byte;
  assign out_payload_index = out_res_r.payload_index;
  assign out_frame_length  = out_res_r.frame_length;

endmodule

`default_nettype wire

@@ rtl/sidfr_step.sv @@
// sidfr_step: per-word frame parser step, next state and result from one byte
// depends on sidfr_pkg
`default_nettype none

module sidfr_step (
  input  wire sidfr_pkg::state_t              st,
  input  wire sidfr_pkg::ids_t                ids,
  input  wire [sidfr_pkg::BYTE_W-1:0]         rx_byte,
  output sidfr_pkg::state_t                   st_nxt,
  output sidfr_pkg::result_t                  res
);

  logic [sidfr_pkg::BYTE_W:0]    sum_wide;
  logic [sidfr_pkg::BYTE_W-1:0]  sum_mod;
  logic [sidfr_pkg::LEN_W-1:0]   cnt_inc;

  // running sum modulo 255, operands stay below twice the modulus
  assign sum_wide = {1'b0, st.running_sum} + {1'b0, rx_byte};
  assign sum_mod  = (sum_wide >= sidfr_pkg::CHECK_MOD)
                    ? sidfr_pkg::BYTE_W'(sum_wide - sidfr_pkg::CHECK_MOD)
                    : sum_wide[sidfr_pkg::BYTE_W-1:0];
  assign cnt_inc  = st.byte_counter + sidfr_pkg::LEN_W'(1);

  always_comb begin
    st_nxt            = st;
    res.status        = sidfr_pkg::ST_NONE;
    res.payload_byte  = '0;
    res.payload_index = '0;
    unique case (st.phase)
      sidfr_pkg::PH_SYNC1: begin
        if (rx_byte == sidfr_pkg::SYNC_BYTE) begin
          st_nxt.phase        = sidfr_pkg::PH_SYNC2;
          st_nxt.length       = '0;
          st_nxt.byte_counter = '0;
          // 0xff mod 255 is zero
          st_nxt.running_sum  = '0;
        end
      end
      sidfr_pkg::PH_SYNC2: begin
        if (rx_byte == sidfr_pkg::SYNC_BYTE) begin
          st_nxt.phase       = sidfr_pkg::PH_SENDER;
          st_nxt.running_sum = sum_mod;
        end else begin
          st_nxt.phase = sidfr_pkg::PH_SYNC1;
          res.status   = sidfr_pkg::ST_SYNC2_MISSING;
        end
      end
      sidfr_pkg::PH_SENDER: begin
        if (rx_byte == ids.partner_id) begin
          st_nxt.phase       = sidfr_pkg::PH_RECEIVER;
          st_nxt.running_sum = sum_mod;
        end else begin
          st_nxt.phase = sidfr_pkg::PH_SYNC1;
          res.status   = sidfr_pkg::ST_SENDER_BAD;
        end
      end
      sidfr_pkg::PH_RECEIVER: begin
        if (rx_byte == ids.own_id) begin
          st_nxt.phase       = sidfr_pkg::PH_LEN_H;
          st_nxt.running_sum = sum_mod;
        end else begin
          st_nxt.phase = sidfr_pkg::PH_SYNC1;
          res.status   = sidfr_pkg::ST_RECEIVER_BAD;
        end
      end
      sidfr_pkg::PH_LEN_H: begin
        st_nxt.running_sum = sum_mod;
        st_nxt.length      = st.length | {rx_byte, sidfr_pkg::BYTE_W'(0)};
        st_nxt.phase       = sidfr_pkg::PH_LEN_L;
      end
      sidfr_pkg::PH_LEN_L: begin
        st_nxt.running_sum = sum_mod;
        st_nxt.length      = st.length | {sidfr_pkg::BYTE_W'(0), rx_byte};
        st_nxt.phase       = sidfr_pkg::PH_PAYLOAD;
      end
      sidfr_pkg::PH_PAYLOAD: begin
        st_nxt.running_sum  = sum_mod;
        res.status          = sidfr_pkg::ST_PAYLOAD;
        res.payload_byte    = rx_byte;
        res.payload_index   = st.byte_counter;
        st_nxt.byte_counter = cnt_inc;
        // zero length still takes one payload word
        if (cnt_inc >= st.length) begin
          st_nxt.phase = sidfr_pkg::PH_CHECK;
        end
      end
      default: begin
        if (rx_byte == st.running_sum) begin
          res.status         = sidfr_pkg::ST_GOOD;
          st_nxt.running_sum = '0;
        end else begin
          res.status = sidfr_pkg::ST_CHECK_ERR;
        end
        st_nxt.phase = sidfr_pkg::PH_SYNC1;
      end
    endcase
    res.frame_length = st_nxt.length;
  end

endmodule

`default_nettype wire
